// File: rtl/hufd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Shared constants, the queue entry type and the walker state encoding.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int HufdAlphabetSize = 256;

  localparam int IdW     = 9;
  localparam int SymW    = 8;
  localparam int SlotW   = 8;
  localparam int DataW   = 8;
  localparam int CntW    = 4;
  localparam int BitIdxW = 3;
  localparam int EntryW  = 2 * IdW;

  localparam int NodeSlots = 1 << SlotW;

  localparam logic [IdW-1:0]  RootReset = 9'd256;
  localparam logic [CntW-1:0] MaxBits   = 4'd8;

  // The queue depth must be a power of two so that the pointers wrap freely.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } hufd_func_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    hufd_func_e            func;
    logic [SlotW-1:0]      slot;
    logic [IdW-1:0]        left;
    logic [IdW-1:0]        right;
    logic [DataW-1:0]      data;
    logic [CntW-1:0]       cnt;
    logic                  eob;
  } hufd_req_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BIT   = 2'd1,
    ST_END   = 2'd2,
    ST_FLUSH = 2'd3
  } hufd_state_e;

endpackage

// File: rtl/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Loads a code tree into a node table and decodes coded bytes LSB first.
// ----------------------------------------------------------------------------
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+-------------------------------------
//   in       | in_valid_i / in_stall_o  | func, node_slot, children, data, ...
//   out      | out_valid_o / out_stall_i| symbol, symbol_valid, corrupt, last
//   cfg      | cfg_we_i                 | cfg_wdata_i (root id)
//
// A request passes through the front register and then the queue before the
// walker sees it. The walker writes a load into the node table; a decode starts
// in the idle state, walks one coded bit per cycle (up to 8) unless a symbol must
// wait for the output, then sends the held last symbol and a corruption report,
// where there are any. Reset puts the root and the walk at id 256; the node
// table is not cleared. A stalled output holds the walker, while the front and
// queue keep taking requests until the queue fills.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder import hufd_pkg::*; #(
  parameter int AlphabetSize = HufdAlphabetSize
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdW-1:0]    cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [SlotW-1:0]  node_slot_i,
  input  logic [IdW-1:0]    left_child_i,
  input  logic [IdW-1:0]    right_child_i,
  input  logic [DataW-1:0]  data_byte_i,
  input  logic [CntW-1:0]   bit_count_i,
  input  logic              end_of_buffer_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              symbol_valid_o,
  output logic              corrupt_o,
  output logic              last_o
);

  logic      push;
  hufd_req_t push_req;
  logic      q_full;
  logic      q_valid;
  hufd_req_t q_req;
  logic      pop;

  hufd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .node_slot_i     (node_slot_i),
    .left_child_i    (left_child_i),
    .right_child_i   (right_child_i),
    .data_byte_i     (data_byte_i),
    .bit_count_i     (bit_count_i),
    .end_of_buffer_i (end_of_buffer_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_req_o      (push_req)
  );

  hufd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_req_o  (q_req)
  );

  hufd_back #(
    .AlphabetSize (AlphabetSize)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_req_i        (q_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .symbol_valid_o (symbol_valid_o),
    .corrupt_o      (corrupt_o),
    .last_o         (last_o)
  );

endmodule

// File: rtl/hufd_front.sv
// ----------------------------------------------------------------------------
// Huffman decoder front end
// Registers incoming requests, clamps the bit count and hands them to the queue.
// ----------------------------------------------------------------------------
module hufd_front import hufd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [SlotW-1:0]     node_slot_i,
  input  logic [IdW-1:0]       left_child_i,
  input  logic [IdW-1:0]       right_child_i,
  input  logic [DataW-1:0]     data_byte_i,
  input  logic [CntW-1:0]      bit_count_i,
  input  logic                 end_of_buffer_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output hufd_req_t            push_req_o
);

  logic      valid_q, valid_d;
  hufd_req_t req_q, req_d;
  logic      accept;

  assign in_stall_o = valid_q && q_full_i;
  assign push_o     = valid_q && !q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_req_o = req_q;

  always_comb begin
    req_d       = req_q;
    req_d.func  = hufd_func_e'(func_i);
    req_d.slot  = node_slot_i;
    req_d.left  = left_child_i;
    req_d.right = right_child_i;
    req_d.data  = data_byte_i;
    // Counts above a full byte walk the whole byte.
    req_d.cnt   = (bit_count_i > MaxBits) ? MaxBits : bit_count_i;
    req_d.eob   = end_of_buffer_i;
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

endmodule

// File: rtl/hufd_queue.sv
// ----------------------------------------------------------------------------
// Huffman decoder request queue
// Short FIFO that decouples the front end from the tree walker.
// ----------------------------------------------------------------------------
module hufd_queue import hufd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hufd_req_t  push_req_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output hufd_req_t  pop_req_o
);

  hufd_req_t         slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_req_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// File: rtl/hufd_back.sv
// ----------------------------------------------------------------------------
// Huffman decoder tree walker
// Holds the node table and walks it one coded bit per cycle while the output can take its symbols.
// ----------------------------------------------------------------------------
module hufd_back import hufd_pkg::*; #(
  parameter int AlphabetSize = HufdAlphabetSize
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdW-1:0]    cfg_wdata_i,
  input  logic              q_valid_i,
  input  hufd_req_t         q_req_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              symbol_valid_o,
  output logic              corrupt_o,
  output logic              last_o
);

  localparam logic [IdW-1:0] LeafLimit = IdW'(AlphabetSize);

  function automatic logic [SlotW-1:0] slot_of(input logic [IdW-1:0] id);
    logic [IdW-1:0] diff;
    diff = id - LeafLimit;
    return diff[SlotW-1:0];
  endfunction

  hufd_state_e          state_q, state_d;
  logic [IdW-1:0]       root_q, root_d;
  logic [IdW-1:0]       walk_q, walk_d;
  logic [DataW-1:0]     data_q, data_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [BitIdxW-1:0]   idx_q, idx_d;
  logic                 eob_q, eob_d;

  logic [EntryW-1:0]    node_mem_q [NodeSlots];
  logic [EntryW-1:0]    rd_q;
  logic                 mem_we;

  logic                 out_valid_q, out_valid_d;
  logic [SymW-1:0]      symbol_q, symbol_d;
  logic                 sym_valid_q, sym_valid_d;
  logic                 corrupt_q, corrupt_d;
  logic                 last_q, last_d;
  logic                 emit;
  logic                 out_free;

  logic                 pend_valid_q, pend_valid_d;
  logic [SymW-1:0]      pend_sym_q, pend_sym_d;
  logic                 bit_adv;

  logic                 root_leaf;
  logic                 cur_bit;
  logic [IdW-1:0]       next_id;
  logic                 next_leaf;
  logic [IdW-1:0]       walk_new;
  logic                 final_bit;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign root_leaf = (root_q < LeafLimit);
  assign cur_bit   = data_q[idx_q];
  assign next_id   = cur_bit ? rd_q[EntryW-1:IdW] : rd_q[IdW-1:0];
  assign next_leaf = (next_id < LeafLimit);
  assign walk_new  = next_leaf ? root_q : next_id;
  assign final_bit = ({1'b0, idx_q} == (cnt_q - 4'd1));
  // A new symbol can only be held once the one before it has gone out.
  assign bit_adv   = !(next_leaf && pend_valid_q && !out_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_req_i.func == FUNC_DECODE && !root_leaf) begin
          if (q_req_i.cnt != '0) begin
            state_d = ST_BIT;
          end else if (q_req_i.eob && walk_q != root_q) begin
            state_d = ST_END;
          end
        end
      end
      ST_BIT: begin
        if (bit_adv && final_bit) begin
          if (eob_q && walk_new != root_q) begin
            state_d = ST_END;
          end else if (next_leaf || pend_valid_q) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (out_free && !pend_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and result generation. Each decoded symbol waits in the holding
  // register until it is known whether it is the last result of its request.
  always_comb begin
    root_d       = root_q;
    walk_d       = walk_q;
    data_d       = data_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    eob_d        = eob_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    emit         = 1'b0;
    symbol_d     = '0;
    sym_valid_d  = 1'b0;
    corrupt_d    = 1'b0;
    last_d       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          root_d = cfg_wdata_i;
          walk_d = cfg_wdata_i;
        end else if (q_valid_i) begin
          if (q_req_i.func == FUNC_LOAD) begin
            pop_o  = 1'b1;
            mem_we = 1'b1;
          end else if (root_leaf) begin
            // A leaf root cannot decode anything; report it and stay put.
            if (out_free) begin
              pop_o     = 1'b1;
              emit      = 1'b1;
              corrupt_d = 1'b1;
              last_d    = 1'b1;
              walk_d    = root_q;
            end
          end else begin
            pop_o  = 1'b1;
            data_d = q_req_i.data;
            cnt_d  = q_req_i.cnt;
            eob_d  = q_req_i.eob;
            idx_d  = '0;
            if (q_req_i.cnt == '0 && q_req_i.eob && walk_q == root_q) begin
              walk_d = root_q;
            end
          end
        end
      end
      ST_BIT: begin
        if (bit_adv) begin
          walk_d = walk_new;
          idx_d  = idx_q + 1'b1;
          if (next_leaf) begin
            pend_valid_d = 1'b1;
            pend_sym_d   = next_id[SymW-1:0];
            if (pend_valid_q) begin
              emit        = 1'b1;
              symbol_d    = pend_sym_q;
              sym_valid_d = 1'b1;
            end
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_valid_q) begin
            symbol_d     = pend_sym_q;
            sym_valid_d  = 1'b1;
            pend_valid_d = 1'b0;
          end else begin
            corrupt_d = 1'b1;
            last_d    = 1'b1;
            walk_d    = root_q;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit         = 1'b1;
          symbol_d     = pend_sym_q;
          sym_valid_d  = 1'b1;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // The read address follows the next walk position so data is ready in time.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[q_req_i.slot] <= {q_req_i.right, q_req_i.left};
    end
    rd_q <= node_mem_q[slot_of(walk_d)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_q       <= RootReset;
      walk_q       <= RootReset;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      root_q       <= root_d;
      walk_q       <= walk_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    cnt_q      <= cnt_d;
    eob_q      <= eob_d;
    pend_sym_q <= pend_sym_d;
    if (emit) begin
      symbol_q    <= symbol_d;
      sym_valid_q <= sym_valid_d;
      corrupt_q   <= corrupt_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign symbol_valid_o = sym_valid_q;
  assign corrupt_o      = corrupt_q;
  assign last_o         = last_q;

endmodule

// File: bench/tb_huffman_tree_walk_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder testbench
// Loads small code trees, sets the root register and streams coded bytes into
// the decoder while both sides stall at random, apart from a last phase with no
// stalls. A short table of directed requests covers the corner cases; random
// trees and byte streams follow. Every decoded symbol and corruption report is
// checked against a predictor that walks its own copy of the node table, or
// against a result typed into the directed table.
module tb_huffman_tree_walk_decoder;
  import hufd_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            sv;
    logic            cor;
    logic            last;
  } sym_res_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef enum int {
    EXP_PREDICTED,
    EXP_NONE,
    EXP_ONE
  } exp_src_e;

  typedef struct {
    row_kind_e       kind;
    logic [IdW-1:0]  root;
    hufd_req_t       req;
    exp_src_e        src;
    sym_res_t        typed;
  } dir_row_t;

  localparam sym_res_t NO_RES      = '0;
  localparam sym_res_t CORRUPT_RES = '{sym: 8'd0, sv: 1'b0, cor: 1'b1, last: 1'b1};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IdW-1:0]   cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             func_i;
  logic [SlotW-1:0] node_slot_i;
  logic [IdW-1:0]   left_child_i;
  logic [IdW-1:0]   right_child_i;
  logic [DataW-1:0] data_byte_i;
  logic [CntW-1:0]  bit_count_i;
  logic             end_of_buffer_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [SymW-1:0]  symbol_o;
  logic             symbol_valid_o;
  logic             corrupt_o;
  logic             last_o;

  // Predictor state.
  logic [EntryW-1:0] tree_tbl [NodeSlots];
  logic [IdW-1:0]    root_reg;
  logic [IdW-1:0]    walk_pos;

  sym_res_t sym_due_q [$];
  int       mismatch_cnt = 0;
  int       quiet_cycles = 0;
  int       in_idle_pct;
  int       out_idle_pct;
  dir_row_t dir_tbl [25];

  huffman_tree_walk_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .node_slot_i     (node_slot_i),
    .left_child_i    (left_child_i),
    .right_child_i   (right_child_i),
    .data_byte_i     (data_byte_i),
    .bit_count_i     (bit_count_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .symbol_o        (symbol_o),
    .symbol_valid_o  (symbol_valid_o),
    .corrupt_o       (corrupt_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_walk(input hufd_req_t r, ref sym_res_t res_q[$]);
    logic [CntW-1:0]   nbits;
    logic [EntryW-1:0] node;
    logic [IdW-1:0]    next_id;
    int                j;
    res_q.delete();
    if (r.func == FUNC_LOAD) begin
      tree_tbl[r.slot] = {r.right, r.left};
      return;
    end
    if (root_reg < HufdAlphabetSize) begin
      walk_pos = root_reg;
      res_q.push_back(CORRUPT_RES);
      return;
    end
    nbits = (r.cnt > MaxBits) ? MaxBits : r.cnt;
    for (j = 0; j < nbits; j++) begin
      node    = tree_tbl[SlotW'(walk_pos - HufdAlphabetSize)];
      next_id = r.data[j] ? node[EntryW-1:IdW] : node[IdW-1:0];
      if (next_id < HufdAlphabetSize) begin
        res_q.push_back('{sym: next_id[SymW-1:0], sv: 1'b1, cor: 1'b0, last: 1'b0});
        walk_pos = root_reg;
      end else begin
        walk_pos = next_id;
      end
    end
    if (r.eob) begin
      if (walk_pos != root_reg) begin
        res_q.push_back('{sym: '0, sv: 1'b0, cor: 1'b1, last: 1'b0});
      end
      walk_pos = root_reg;
    end
    if (res_q.size() > 0) begin
      res_q[res_q.size()-1].last = 1'b1;
    end
  endfunction

  // Entered and left at a falling edge.
  task automatic send_req(input hufd_req_t r, input exp_src_e src, input sym_res_t typed);
    sym_res_t res_q [$];
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= r.func;
    node_slot_i     <= r.slot;
    left_child_i    <= r.left;
    right_child_i   <= r.right;
    data_byte_i     <= r.data;
    bit_count_i     <= r.cnt;
    end_of_buffer_i <= r.eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_walk(r, res_q);
    if (src == EXP_PREDICTED) begin
      foreach (res_q[i]) sym_due_q.push_back(res_q[i]);
    end else if (src == EXP_ONE) begin
      sym_due_q.push_back(typed);
    end
    @(negedge clk_i);
  endtask

  // Loads carry no result, so a settling wait follows the last symbol before the
  // decoder counts as idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sym_due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_root(input logic [IdW-1:0] root);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= root;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    root_reg = root;
    walk_pos = root;
  endtask

  function automatic hufd_req_t random_req(input hufd_func_e func);
    hufd_req_t r;
    int        pick;
    r.func  = func;
    r.slot  = SlotW'($urandom_range(255));
    r.left  = IdW'($urandom_range(511));
    r.right = IdW'($urandom_range(511));
    r.data  = DataW'($urandom_range(255));
    r.eob   = ($urandom_range(4) == 0);
    pick    = $urandom_range(19);
    if (pick < 10) begin
      r.cnt = MaxBits;
    end else if (pick < 16) begin
      r.cnt = CntW'($urandom_range(8, 1));
    end else if (pick < 17) begin
      r.cnt = '0;
    end else begin
      r.cnt = CntW'($urandom_range(15, 9));
    end
    return r;
  endfunction

  // A child is a leaf or another node of the current tree, so the walk never
  // reaches a slot that was not written.
  function automatic logic [IdW-1:0] tree_child(input logic [SlotW-1:0] slots[$]);
    if ($urandom_range(9) < 5) begin
      return IdW'($urandom_range(255));
    end
    return {1'b1, slots[$urandom_range(slots.size() - 1)]};
  endfunction

  task automatic run_random_phase(input int n_items);
    logic [SlotW-1:0] tree_slots [$];
    hufd_req_t        r;
    logic [IdW-1:0]   new_root;
    int               n_nodes;
    int               pick;
    bit               hit;
    n_nodes = $urandom_range(8, 2);
    repeat (n_nodes) tree_slots.push_back(SlotW'($urandom_range(255)));
    if ($urandom_range(5) == 0) begin
      new_root = IdW'($urandom_range(255));
    end else begin
      new_root = {1'b1, tree_slots[0]};
    end
    wait_drained();
    write_root(new_root);
    foreach (tree_slots[i]) begin
      r       = random_req(FUNC_LOAD);
      r.slot  = tree_slots[i];
      r.left  = tree_child(tree_slots);
      r.right = tree_child(tree_slots);
      send_req(r, EXP_PREDICTED, NO_RES);
    end
    repeat (n_items - n_nodes) begin
      pick = $urandom_range(19);
      if (pick < 2) begin
        r       = random_req(FUNC_LOAD);
        r.slot  = tree_slots[$urandom_range(tree_slots.size() - 1)];
        r.left  = tree_child(tree_slots);
        r.right = tree_child(tree_slots);
      end else if (pick < 4) begin
        // A stray write outside the tree may hold any children at all.
        r   = random_req(FUNC_LOAD);
        hit = 1'b0;
        foreach (tree_slots[i]) if (tree_slots[i] == r.slot) hit = 1'b1;
        if (hit) begin
          r.left  = tree_child(tree_slots);
          r.right = tree_child(tree_slots);
        end
      end else begin
        r = random_req(FUNC_DECODE);
      end
      send_req(r, EXP_PREDICTED, NO_RES);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    sym_res_t want;
    sym_res_t got;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{sym: symbol_o, sv: symbol_valid_o, cor: corrupt_o, last: last_o};
      if (sym_due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got sym=%0d sv=%0b corrupt=%0b last=%0b",
                 $time, got.sym, got.sv, got.cor, got.last);
        mismatch_cnt++;
      end else begin
        want = sym_due_q.pop_front();
        if (got.sym !== want.sym || got.sv !== want.sv || got.cor !== want.cor ||
            got.last !== want.last) begin
          $display("%0t: mismatch: expected sym=%0d sv=%0b corrupt=%0b last=%0b, got sym=%0d sv=%0b corrupt=%0b last=%0b",
                   $time, want.sym, want.sv, want.cor, want.last,
                   got.sym, got.sv, got.cor, got.last);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    func_i          = FUNC_LOAD;
    node_slot_i     = '0;
    left_child_i    = '0;
    right_child_i   = '0;
    data_byte_i     = '0;
    bit_count_i     = '0;
    end_of_buffer_i = 1'b0;
    out_stall_i     = 1'b0;
    in_idle_pct     = 12;
    out_idle_pct    = 69;
    root_reg        = RootReset;
    walk_pos        = RootReset;
    foreach (tree_tbl[i]) tree_tbl[i] = '0;

    // Tree after the first three loads: 256 -> {65, 257}, 257 -> {255, 0},
    // 511 -> {511, 256}. Later 384 -> {200, 256}.
    dir_tbl = '{
      '{ROW_REQ, 9'd0,   '{FUNC_LOAD,   8'd0,   9'd65,  9'd257, 8'h00, 4'd0,  1'b0}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_LOAD,   8'd1,   9'd255, 9'd0,   8'h00, 4'd0,  1'b0}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_LOAD,   8'd255, 9'd511, 9'd256, 8'h00, 4'd0,  1'b0}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd1,  1'b0}, EXP_ONE,
        '{8'd65, 1'b1, 1'b0, 1'b1}},
      // Ends one bit into a code.
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h01, 4'd1,  1'b1}, EXP_ONE, CORRUPT_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'hFF, 4'd8,  1'b0}, EXP_PREDICTED, NO_RES},
      // A count above eight saturates.
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'hAA, 4'd15, 1'b1}, EXP_PREDICTED, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd0,  1'b1}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'hFF, 4'd0,  1'b0}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h02, 4'd2,  1'b0}, EXP_ONE,
        '{8'd65, 1'b1, 1'b0, 1'b1}},
      // The walk was left mid-code by the request before.
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd0,  1'b1}, EXP_ONE, CORRUPT_RES},
      '{ROW_CFG, 9'd511, '0, EXP_NONE, NO_RES},
      // The left child of 511 is 511 itself, so the walk ends back on the root.
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd8,  1'b1}, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'hFE, 4'd8,  1'b0}, EXP_PREDICTED, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h5A, 4'd9,  1'b1}, EXP_PREDICTED, NO_RES},
      // A leaf as root reports corruption on every decode request.
      '{ROW_CFG, 9'd0,   '0, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'hFF, 4'd8,  1'b0}, EXP_ONE, CORRUPT_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd0,  1'b1}, EXP_ONE, CORRUPT_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_LOAD,   8'd128, 9'd200, 9'd256, 8'hFF, 4'd15, 1'b1}, EXP_NONE, NO_RES},
      '{ROW_CFG, 9'd255, '0, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h55, 4'd4,  1'b1}, EXP_ONE, CORRUPT_RES},
      '{ROW_CFG, 9'd384, '0, EXP_NONE, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h00, 4'd1,  1'b0}, EXP_ONE,
        '{8'd200, 1'b1, 1'b0, 1'b1}},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd0,   9'd0,   9'd0,   8'h03, 4'd2,  1'b1}, EXP_PREDICTED, NO_RES},
      '{ROW_REQ, 9'd0,   '{FUNC_DECODE, 8'd255, 9'd511, 9'd511, 8'h01, 4'd1,  1'b0}, EXP_PREDICTED, NO_RES}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        wait_drained();
        write_root(dir_tbl[i].root);
      end else begin
        send_req(dir_tbl[i].req, dir_tbl[i].src, dir_tbl[i].typed);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 12;
          out_idle_pct = 69;
        end
        1: begin
          in_idle_pct  = 69;
          out_idle_pct = 12;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      repeat (2) run_random_phase(32);
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
